/* src/krsp_pkg.sv */
package krsp_pkg;

  localparam int KEY_ID_LEN_DEF = 16;
  localparam int LINE_LIMIT_DEF = 128;
  localparam int FILE_LIMIT_DEF = 512;

  localparam int SECRET_BYTES = 32;
  localparam int SECRET_CHARS = 52;
  localparam int SUITE_LEN    = 25;
  localparam int YES_LEN      = 3;
  localparam int ADDR_W       = 5;

  localparam logic [2:0] LN_VERSION = 3'd0;
  localparam logic [2:0] LN_SUITE   = 3'd1;
  localparam logic [2:0] LN_KEY_ID  = 3'd2;
  localparam logic [2:0] LN_SECRET  = 3'd3;
  localparam logic [2:0] LN_ENABLED = 3'd4;
  localparam logic [2:0] LN_TOTAL   = 3'd5;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_ONE = 8'h31;

  localparam logic [8*SUITE_LEN-1:0] SUITE_TEXT = "OCRA-1:HOTP-SHA256-8:QN10";
  localparam logic [8*YES_LEN-1:0]   YES_TEXT   = "yes";

  typedef enum logic [1:0] {
    KIND_VERDICT = 2'd0,
    KIND_KEY     = 2'd1,
    KIND_SECRET  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       ok;
    logic       last_result;
  } out_item_t;

  // store writes and end-of-file event from the parser
  typedef struct packed {
    logic              key_we;
    logic              sec_we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              run_end;
    logic              run_good;
  } parse_evt_t;

  function automatic logic [2:0] name_len(input logic [2:0] ln);
    case (ln)
      LN_VERSION: name_len = 3'd7;
      LN_SUITE:   name_len = 3'd5;
      LN_KEY_ID:  name_len = 3'd6;
      LN_SECRET:  name_len = 3'd6;
      default:    name_len = 3'd7;
    endcase
  endfunction

  function automatic logic [7:0] name_char(input logic [2:0] ln, input logic [2:0] idx);
    logic [55:0] s;
    int          pos;
    case (ln)
      LN_VERSION: s = 56'("version");
      LN_SUITE:   s = 56'("suite");
      LN_KEY_ID:  s = 56'("key_id");
      LN_SECRET:  s = 56'("secret");
      default:    s = 56'("enabled");
    endcase
    pos = (int'(name_len(ln)) - 1 - int'(idx)) & 7;
    name_char = s[8*pos +: 8];
  endfunction

  function automatic logic [7:0] suite_char(input logic [4:0] idx);
    int pos;
    pos = (SUITE_LEN - 1 - int'(idx)) % 32;
    if (pos < 0 || pos >= SUITE_LEN) begin
      suite_char = 8'h00;
    end else begin
      suite_char = SUITE_TEXT[8*pos +: 8];
    end
  endfunction

  function automatic logic [7:0] yes_char(input logic [1:0] idx);
    int pos;
    pos = YES_LEN - 1 - int'(idx);
    if (pos < 0) begin
      yes_char = 8'h00;
    end else begin
      yes_char = YES_TEXT[8*pos +: 8];
    end
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
             (b >= 8'h41 && b <= 8'h46);
  endfunction

endpackage

/* src/krsp_parser.sv */
module krsp_parser
  import krsp_pkg::*;
#(
  parameter int KEY_ID_LEN = KEY_ID_LEN_DEF,
  parameter int LINE_LIMIT = LINE_LIMIT_DEF,
  parameter int FILE_LIMIT = FILE_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  in_item_t   item,
  output parse_evt_t evt
);

  logic [9:0]  file_count_r,   file_count_nxt;
  logic [2:0]  line_number_r,  line_number_nxt;
  logic [7:0]  column_r,       column_nxt;
  logic        match_ok_r,     match_ok_nxt;
  logic        error_flag_r,   error_flag_nxt;
  logic [12:0] bit_pool_r,     bit_pool_nxt;
  logic [3:0]  pool_bits_r,    pool_bits_nxt;
  logic [5:0]  secret_index_r, secret_index_nxt;

  logic [7:0]  b;
  logic [7:0]  n;
  logic [7:0]  v;
  logic [7:0]  vlen;
  logic        line_good;
  logic        sym_ok;
  logic [4:0]  sym;
  logic [12:0] pool_sh;
  logic [3:0]  bits_add;
  logic [3:0]  bits_rem;

  assign b = item.in_byte;
  assign n = {5'd0, name_len(line_number_r)};
  assign v = column_r - n - 8'd1;

  always_comb begin
    case (line_number_r)
      LN_VERSION: vlen = 8'd1;
      LN_SUITE:   vlen = 8'(SUITE_LEN);
      LN_KEY_ID:  vlen = 8'(KEY_ID_LEN);
      LN_SECRET:  vlen = 8'(SECRET_CHARS);
      default:    vlen = 8'(YES_LEN);
    endcase
  end

  // base32 symbol decode
  always_comb begin
    sym_ok = 1'b1;
    sym    = 5'd0;
    if (b >= 8'h41 && b <= 8'h5A) begin
      sym = 5'(b - 8'h41);
    end else if (b >= 8'h32 && b <= 8'h37) begin
      sym = 5'(b - 8'h32 + 8'd26);
    end else begin
      sym_ok = 1'b0;
    end
  end

  assign pool_sh  = {bit_pool_r[7:0], sym};
  assign bits_add = pool_bits_r + 4'd5;
  assign bits_rem = bits_add - 4'd8;

  always_comb begin
    file_count_nxt   = file_count_r;
    line_number_nxt  = line_number_r;
    column_nxt       = column_r;
    match_ok_nxt     = match_ok_r;
    error_flag_nxt   = error_flag_r;
    bit_pool_nxt     = bit_pool_r;
    pool_bits_nxt    = pool_bits_r;
    secret_index_nxt = secret_index_r;
    evt              = '0;
    line_good        = 1'b0;

    if (accept) begin
      if (!error_flag_r) begin
        if (file_count_r >= 10'(FILE_LIMIT)) begin
          error_flag_nxt = 1'b1;
        end else begin
          file_count_nxt = file_count_r + 10'd1;
          if (b == CH_NUL || b == CH_CR) begin
            error_flag_nxt = 1'b1;
          end else if (b == CH_LF) begin
            if (column_r == 8'd0 || line_number_r >= LN_TOTAL) begin
              error_flag_nxt = 1'b1;
            end else begin
              line_good = match_ok_r && (column_r == n + 8'd1 + vlen);
              if (line_number_r == LN_SECRET) begin
                line_good = line_good && secret_index_r == 6'(SECRET_BYTES) &&
                            pool_bits_r == 4'd4 && bit_pool_r == 13'd0;
              end
              if (!line_good) begin
                error_flag_nxt = 1'b1;
              end else begin
                line_number_nxt = line_number_r + 3'd1;
                column_nxt      = 8'd0;
                match_ok_nxt    = 1'b1;
              end
            end
          end else begin
            if (column_r >= 8'(LINE_LIMIT) || line_number_r >= LN_TOTAL) begin
              error_flag_nxt = 1'b1;
            end else begin
              column_nxt = column_r + 8'd1;
              if (column_r < n) begin
                if (b != name_char(line_number_r, column_r[2:0])) match_ok_nxt = 1'b0;
              end else if (column_r == n) begin
                if (b != CH_EQ) match_ok_nxt = 1'b0;
              end else if (match_ok_r) begin
                case (line_number_r)
                  LN_VERSION: begin
                    if (v != 8'd0 || b != CH_ONE) match_ok_nxt = 1'b0;
                  end
                  LN_SUITE: begin
                    if (v >= 8'(SUITE_LEN) || b != suite_char(v[4:0])) match_ok_nxt = 1'b0;
                  end
                  LN_KEY_ID: begin
                    if (v >= 8'(KEY_ID_LEN) || !is_hex(b)) begin
                      match_ok_nxt = 1'b0;
                    end else begin
                      evt.key_we = 1'b1;
                      evt.addr   = v[ADDR_W-1:0];
                      evt.data   = b;
                    end
                  end
                  LN_SECRET: begin
                    if (v >= 8'(SECRET_CHARS) || !sym_ok) begin
                      match_ok_nxt = 1'b0;
                    end else begin
                      bit_pool_nxt  = pool_sh;
                      pool_bits_nxt = bits_add;
                      if (bits_add >= 4'd8) begin
                        pool_bits_nxt = bits_rem;
                        if (secret_index_r >= 6'(SECRET_BYTES)) begin
                          match_ok_nxt = 1'b0;
                        end else begin
                          evt.sec_we       = 1'b1;
                          evt.addr         = secret_index_r[ADDR_W-1:0];
                          evt.data         = 8'(pool_sh >> bits_rem);
                          secret_index_nxt = secret_index_r + 6'd1;
                          bit_pool_nxt     = pool_sh & ((13'd1 << bits_rem) - 13'd1);
                        end
                      end
                    end
                  end
                  default: begin
                    if (v >= 8'(YES_LEN) || b != yes_char(v[1:0])) match_ok_nxt = 1'b0;
                  end
                endcase
              end
            end
          end
        end
      end

      if (item.is_last) begin
        evt.run_end  = 1'b1;
        evt.run_good = !error_flag_nxt && b == CH_LF && line_number_nxt == LN_TOTAL;
        // fresh file starts with the next byte
        file_count_nxt   = 10'd0;
        line_number_nxt  = 3'd0;
        column_nxt       = 8'd0;
        match_ok_nxt     = 1'b1;
        error_flag_nxt   = 1'b0;
        bit_pool_nxt     = 13'd0;
        pool_bits_nxt    = 4'd0;
        secret_index_nxt = 6'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_count_r   <= 10'd0;
      line_number_r  <= 3'd0;
      column_r       <= 8'd0;
      match_ok_r     <= 1'b1;
      error_flag_r   <= 1'b0;
      bit_pool_r     <= 13'd0;
      pool_bits_r    <= 4'd0;
      secret_index_r <= 6'd0;
    end else begin
      file_count_r   <= file_count_nxt;
      line_number_r  <= line_number_nxt;
      column_r       <= column_nxt;
      match_ok_r     <= match_ok_nxt;
      error_flag_r   <= error_flag_nxt;
      bit_pool_r     <= bit_pool_nxt;
      pool_bits_r    <= pool_bits_nxt;
      secret_index_r <= secret_index_nxt;
    end
  end

endmodule

/* src/krsp_emit.sv */
module krsp_emit
  import krsp_pkg::*;
#(
  parameter int KEY_ID_LEN = KEY_ID_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  parse_evt_t evt,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int TOTAL = KEY_ID_LEN + SECRET_BYTES;
  localparam int CNT_W = $clog2(TOTAL);
  localparam int KA_W  = (KEY_ID_LEN > 1) ? $clog2(KEY_ID_LEN) : 1;
  localparam int SA_W  = $clog2(SECRET_BYTES);

  logic [7:0] key_mem [KEY_ID_LEN];
  logic [7:0] sec_mem [SECRET_BYTES];

  logic             active_r,    active_nxt;
  logic             good_r,      good_nxt;
  logic [CNT_W-1:0] idx_r,       idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r,       out_nxt;

  logic             load;
  logic [CNT_W-1:0] sec_idx;

  assign load    = active_r && (!out_valid_r || out_ready);
  assign sec_idx = idx_r - CNT_W'(KEY_ID_LEN);

  always_ff @(posedge clk) begin
    if (evt.key_we) key_mem[evt.addr[KA_W-1:0]] <= evt.data;
    if (evt.sec_we) sec_mem[evt.addr[SA_W-1:0]] <= evt.data;
  end

  always_comb begin
    active_nxt    = active_r;
    good_nxt      = good_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    if (evt.run_end) begin
      active_nxt = 1'b1;
      good_nxt   = evt.run_good;
      idx_nxt    = '0;
    end else if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + CNT_W'(1);
      if (!good_r) begin
        out_nxt    = '{kind: KIND_VERDICT, out_byte: 8'd0, ok: 1'b0, last_result: 1'b1};
        active_nxt = 1'b0;
      end else begin
        out_nxt.ok          = 1'b1;
        out_nxt.last_result = (idx_r == CNT_W'(TOTAL - 1));
        if (idx_r < CNT_W'(KEY_ID_LEN)) begin
          out_nxt.kind     = KIND_KEY;
          out_nxt.out_byte = key_mem[idx_r[KA_W-1:0]];
        end else begin
          out_nxt.kind     = KIND_SECRET;
          out_nxt.out_byte = sec_mem[sec_idx[SA_W-1:0]];
        end
        if (idx_r == CNT_W'(TOTAL - 1)) active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      good_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      good_r      <= good_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign busy      = active_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    evt.run_end |-> !active_r)
    else $error("result burst started while one is running");

  a_verdict_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == KIND_VERDICT |-> !out_r.ok && out_r.last_result)
    else $error("failure verdict malformed");

  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && !good_r |-> idx_r == '0)
    else $error("failure burst longer than one result");

  // a new burst may already be pending behind the final result
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last_result && out_ready && !active_r |=> !out_valid_r)
    else $error("result after final result of a run");
`endif

endmodule

/* src/key_record_stream_parser.sv */
// Key record parser: takes a key-record file one byte per transfer (is_last on the
// final byte) and checks it line by line as it streams in, decoding the base32 secret
// on the fly. Bytes are accepted one per cycle with no gaps while a file streams. When
// the final byte is taken the block emits either one failure verdict or KEY_ID_LEN key
// id characters followed by the 32 secret bytes; in_ready is low from the final byte
// until the last result of that burst is loaded into the single output register, and
// longer if out_ready is held low.
module key_record_stream_parser
  import krsp_pkg::*;
#(
  parameter int KEY_ID_LEN = KEY_ID_LEN_DEF,
  parameter int LINE_LIMIT = LINE_LIMIT_DEF,
  parameter int FILE_LIMIT = FILE_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  parse_evt_t evt;
  logic       busy;
  logic       accept;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  krsp_parser #(
    .KEY_ID_LEN(KEY_ID_LEN),
    .LINE_LIMIT(LINE_LIMIT),
    .FILE_LIMIT(FILE_LIMIT)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .item  (in_data),
    .evt   (evt)
  );

  krsp_emit #(
    .KEY_ID_LEN(KEY_ID_LEN)
  ) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .evt      (evt),
    .busy     (busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

/* test/key_record_checker.sv */
`timescale 1ns / 100ps

module key_record_checker
  import krsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        outstanding
);

  localparam int KEY_LEN = KEY_ID_LEN_DEF;

  // parser state, mirrors the block
  logic [9:0]  byte_cnt;
  logic [2:0]  line_no;
  logic [7:0]  col;
  logic        name_ok;
  logic        bad;
  logic [12:0] pool;
  logic [3:0]  pool_n;
  logic [5:0]  sec_idx;
  logic [7:0]  sec_mem [SECRET_BYTES];
  logic [7:0]  key_mem [KEY_LEN];

  out_item_t parse_results_q [$];
  int        fail_cnt = 0;

  function automatic string field_name(input logic [2:0] ln);
    case (ln)
      LN_VERSION: return "version";
      LN_SUITE:   return "suite";
      LN_KEY_ID:  return "key_id";
      LN_SECRET:  return "secret";
      default:    return "enabled";
    endcase
  endfunction

  function automatic int value_length(input logic [2:0] ln);
    case (ln)
      LN_VERSION: return 1;
      LN_SUITE:   return SUITE_LEN;
      LN_KEY_ID:  return KEY_LEN;
      LN_SECRET:  return SECRET_CHARS;
      default:    return YES_LEN;
    endcase
  endfunction

  function automatic void clear_run();
    byte_cnt = '0;
    line_no  = LN_VERSION;
    col      = '0;
    name_ok  = 1'b1;
    bad      = 1'b0;
    pool     = '0;
    pool_n   = '0;
    sec_idx  = '0;
  endfunction

  function automatic void value_char(input int v, input logic [7:0] b);
    logic [4:0] sym;
    bit         sym_ok;
    sym    = '0;
    sym_ok = 1'b1;
    case (line_no)
      LN_VERSION: if (v != 0 || b != CH_ONE) name_ok = 1'b0;
      LN_SUITE: begin
        if (v >= SUITE_LEN || b != SUITE_TEXT[8*(SUITE_LEN-1-v) +: 8]) name_ok = 1'b0;
      end
      LN_KEY_ID: begin
        if (v >= KEY_LEN ||
            !(b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]})) begin
          name_ok = 1'b0;
        end else begin
          key_mem[v] = b;
        end
      end
      LN_SECRET: begin
        if (v >= SECRET_CHARS) begin
          name_ok = 1'b0;
        end else begin
          if (b >= "A" && b <= "Z") sym = 5'(b - "A");
          else if (b >= "2" && b <= "7") sym = 5'(b - "2" + 26);
          else sym_ok = 1'b0;
          if (!sym_ok) begin
            name_ok = 1'b0;
          end else begin
            pool   = {pool[7:0], sym};
            pool_n = pool_n + 4'd5;
            if (pool_n >= 4'd8) begin
              pool_n = pool_n - 4'd8;
              if (sec_idx >= SECRET_BYTES) begin
                name_ok = 1'b0;
              end else begin
                sec_mem[sec_idx] = 8'(pool >> pool_n);
                sec_idx = sec_idx + 6'd1;
                pool = pool & ((13'd1 << pool_n) - 13'd1);
              end
            end
          end
        end
      end
      default: begin
        if (v >= YES_LEN || b != YES_TEXT[8*(YES_LEN-1-v) +: 8]) name_ok = 1'b0;
      end
    endcase
  endfunction

  function automatic void body_char(input logic [7:0] b);
    string nm;
    int    c;
    int    n;
    c = int'(col);
    if (c >= LINE_LIMIT_DEF || line_no >= LN_TOTAL) begin
      bad = 1'b1;
    end else begin
      col = 8'(c + 1);
      nm  = field_name(line_no);
      n   = nm.len();
      if (c < n) begin
        if (b != nm[c]) name_ok = 1'b0;
      end else if (c == n) begin
        if (b != CH_EQ) name_ok = 1'b0;
      end else if (name_ok) begin
        value_char(c - n - 1, b);
      end
    end
  endfunction

  function automatic void close_line();
    string nm;
    bit    good;
    if (col == 0 || line_no >= LN_TOTAL) begin
      bad = 1'b1;
    end else begin
      nm   = field_name(line_no);
      good = name_ok && (int'(col) == nm.len() + 1 + value_length(line_no));
      // secret must fill all 32 bytes and leave exactly four zero bits
      if (line_no == LN_SECRET) begin
        good = good && sec_idx == SECRET_BYTES && pool_n == 4'd4 && pool == '0;
      end
      if (!good) begin
        bad = 1'b1;
      end else begin
        line_no = line_no + 3'd1;
        col     = '0;
        name_ok = 1'b1;
      end
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic last);
    out_item_t r;
    if (!bad) begin
      if (byte_cnt >= FILE_LIMIT_DEF) begin
        bad = 1'b1;
      end else begin
        byte_cnt = byte_cnt + 10'd1;
        if (b == CH_NUL || b == CH_CR) bad = 1'b1;
        else if (b == CH_LF) close_line();
        else body_char(b);
      end
    end
    if (last) begin
      if (bad || b != CH_LF || line_no != LN_TOTAL) begin
        r.kind        = KIND_VERDICT;
        r.out_byte    = '0;
        r.ok          = 1'b0;
        r.last_result = 1'b1;
        parse_results_q.push_back(r);
      end else begin
        for (int k = 0; k < KEY_LEN; k++) begin
          r.kind        = KIND_KEY;
          r.out_byte    = key_mem[k];
          r.ok          = 1'b1;
          r.last_result = 1'b0;
          parse_results_q.push_back(r);
        end
        for (int k = 0; k < SECRET_BYTES; k++) begin
          r.kind        = KIND_SECRET;
          r.out_byte    = sec_mem[k];
          r.ok          = 1'b1;
          r.last_result = (k == SECRET_BYTES - 1);
          parse_results_q.push_back(r);
        end
      end
      clear_run();
    end
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      clear_run();
      parse_results_q.delete();
    end else begin
      if (in_valid && in_ready) parse_byte(in_data.in_byte, in_data.is_last);
      if (out_valid && out_ready) begin
        if (parse_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d byte %h ok %0d last %0d",
                   $time, out_data.kind, out_data.out_byte, out_data.ok,
                   out_data.last_result);
          fail_cnt++;
        end else begin
          want = parse_results_q.pop_front();
          if (out_data !== want) begin
            $display("%0t: expected kind %0d byte %h ok %0d last %0d, got kind %0d byte %h ok %0d last %0d",
                     $time, want.kind, want.out_byte, want.ok, want.last_result,
                     out_data.kind, out_data.out_byte, out_data.ok, out_data.last_result);
            fail_cnt++;
          end
        end
      end
    end
    mismatches  <= fail_cnt;
    outstanding <= parse_results_q.size();
  end

endmodule

/* test/tb_key_record_stream_parser.sv */
`timescale 1ns / 100ps

module tb_key_record_stream_parser;
  import krsp_pkg::*;

  localparam int CYCLE_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 20;

  typedef enum {SEC_RANDOM, SEC_ZEROS, SEC_ONES} secret_fill_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int mismatches;
  int outstanding;
  int cycle_cnt = 0;
  bit quiet = 1'b0;
  bit calm  = 1'b0;

  logic [7:0] file_buf [$];
  string      hex_set = "0123456789abcdefABCDEF";

  key_record_stream_parser u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  key_record_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_key_record_stream_parser failed");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic logic [7:0] b32_char(input int sym);
    return 8'(sym < 26 ? "A" + sym : "2" + sym - 26);
  endfunction

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) file_buf.push_back(s[i]);
  endtask

  task automatic good_record(input secret_fill_t fill);
    int idx;
    int sym;
    file_buf.delete();
    put_text("version=1\n");
    put_text("suite=OCRA-1:HOTP-SHA256-8:QN10\n");
    put_text("key_id=");
    for (int i = 0; i < KEY_ID_LEN_DEF; i++) begin
      case (fill)
        SEC_ZEROS: idx = i % 22;
        SEC_ONES:  idx = (i + 10) % 22;
        default:   idx = $urandom_range(0, 21);
      endcase
      file_buf.push_back(hex_set[idx]);
    end
    file_buf.push_back(CH_LF);
    put_text("secret=");
    for (int i = 0; i < SECRET_CHARS - 1; i++) begin
      case (fill)
        SEC_ZEROS: sym = 0;
        SEC_ONES:  sym = 31;
        default:   sym = $urandom_range(0, 31);
      endcase
      file_buf.push_back(b32_char(sym));
    end
    // last char carries one data bit and four pad bits that must be zero
    case (fill)
      SEC_ZEROS: sym = 0;
      SEC_ONES:  sym = 16;
      default:   sym = 16 * $urandom_range(0, 1);
    endcase
    file_buf.push_back(b32_char(sym));
    file_buf.push_back(CH_LF);
    put_text("enabled=yes\n");
  endtask

  task automatic send_file();
    for (int i = 0; i < file_buf.size(); i++) begin
      if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= '{in_byte: file_buf[i], is_last: (i == file_buf.size() - 1)};
      do @(posedge clk); while (!in_ready);
    end
    calm = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    file_buf.delete();
    file_buf.push_back(8'hFF);
    send_file();
    file_buf.delete();
    file_buf.push_back(CH_LF);  // empty line
    send_file();
    file_buf.delete();
    put_text("v");
    file_buf.push_back(CH_CR);
    send_file();
    good_record(SEC_RANDOM);
    send_file();

    // no idling from here on
    quiet = 1'b1;
    file_buf.delete();
    put_text("version=2\n");
    send_file();
    file_buf.delete();
    put_text("version=1");  // no final newline
    send_file();
    file_buf.delete();
    file_buf.push_back(CH_NUL);
    send_file();
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_key_record_stream_parser passed");
    end else begin
      $display("tb_key_record_stream_parser failed");
    end
    $finish;
  end

endmodule
